// ===== rtl/core/bivariate_moment_merge_assert.svh =====
// ---------------------------------------------------------------------------
// Bivariate moment merge: assertion macros
// Concurrent assertion wrappers used by the datapath RTL of the block.
// ---------------------------------------------------------------------------
`ifndef BIVARIATE_MOMENT_MERGE_ASSERT_SVH
`define BIVARIATE_MOMENT_MERGE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bivariate_moment_merge: assertion failed");
`define BMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bivariate_moment_merge: assertion failed");
`else
`define BMM_ASSERT_IMP(lbl, ante, cons)
`define BMM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/bmm_pkg.sv =====
// ---------------------------------------------------------------------------
// Bivariate moment merge package
// Payload types, controller/datapath interface types and job codes.
// ---------------------------------------------------------------------------
package bmm_pkg;

  typedef struct packed {
    logic               first_part;
    logic               last_part;
    logic [23:0]        part_count;
    logic signed [31:0] part_mean_x;
    logic signed [31:0] part_mean_y;
    logic [47:0]        part_m2_x;
    logic [47:0]        part_m2_y;
    logic signed [47:0] part_m_xy;
  } bmm_in_t;

  typedef struct packed {
    logic [31:0]        total_count;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic [47:0]        m2_x;
    logic [47:0]        m2_y;
    logic signed [47:0] m_xy;
    logic               saturated;
  } bmm_out_t;

  typedef enum logic [3:0] {
    JOB_X   = 4'd0,
    JOB_SQX = 4'd1,
    JOB_PX  = 4'd2,
    JOB_DX  = 4'd3,
    JOB_XY  = 4'd4,
    JOB_PXY = 4'd5,
    JOB_DXY = 4'd6,
    JOB_SQY = 4'd7,
    JOB_PY  = 4'd8,
    JOB_DY  = 4'd9,
    JOB_MX  = 4'd10,
    JOB_QX  = 4'd11,
    JOB_MY  = 4'd12,
    JOB_QY  = 4'd13
  } bmm_job_t;

  localparam int unsigned MulSteps = 64;
  localparam int unsigned DivSteps = 128;

  typedef struct packed {
    logic     capture;
    logic     init;
    logic     step;
    logic     wb;
    logic     commit;
    bmm_job_t job;
  } bmm_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_blocked;
  } bmm_sts_t;

  function automatic logic job_is_div(bmm_job_t job);
    return (job == JOB_DX) || (job == JOB_DXY) || (job == JOB_DY) ||
           (job == JOB_QX) || (job == JOB_QY);
  endfunction

endpackage

// ===== rtl/core/bivariate_moment_merge.sv =====
// ---------------------------------------------------------------------------
// Bivariate moment merge
// Merges partial count/mean/moment summaries into one running aggregate.
// ---------------------------------------------------------------------------
// One part is taken at a time. A first part, or a merge whose new total count
// is zero, skips the jobs and goes straight to commit. A full merge runs nine
// shift-add multiplications and five restoring divisions, all on one shared
// multiplier and one shared divider, each job with a set-up and a write-back
// state. The aggregate is presented on the output transaction of a part that
// carries last_part; a pending result is held in an output register while
// the next part is already being worked on.
module bivariate_moment_merge
  import bmm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bmm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bmm_out_t out_data
);

  bmm_cmd_t cmd;
  bmm_sts_t sts;

  bmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/bmm_ctrl.sv =====
// ---------------------------------------------------------------------------
// Bivariate moment merge controller
// Sequences the multiply and divide jobs of one merge and the final commit.
// ---------------------------------------------------------------------------
module bmm_ctrl
  import bmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bmm_sts_t sts,
  output bmm_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INIT   = 5'b00010,
    S_RUN    = 5'b00100,
    S_WB     = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t   state_r, state_nxt;
  bmm_job_t job_r, job_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [6:0] cnt_last;

  assign in_ready = (state_r == S_IDLE);
  assign cnt_last = job_is_div(job_r) ? 7'(DivSteps - 1) : 7'(MulSteps - 1);

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.job     = job_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          job_nxt     = JOB_X;
          state_nxt   = S_INIT;
        end
      end
      S_INIT: begin
        if (sts.bypass) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.init  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r == cnt_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (job_r == JOB_QY) begin
          state_nxt = S_COMMIT;
        end else begin
          job_nxt   = bmm_job_t'(job_r + 4'd1);
          state_nxt = S_INIT;
        end
      end
      S_COMMIT: begin
        if (!sts.out_blocked) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= JOB_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/bmm_dp.sv =====
// ---------------------------------------------------------------------------
// Bivariate moment merge datapath
// Aggregate registers, shift-add multiplier, restoring divider and commit.
// ---------------------------------------------------------------------------
module bmm_dp
  import bmm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bmm_in_t  in_data,
  input  bmm_cmd_t cmd,
  output bmm_sts_t sts,
  output logic     out_valid,
  input  logic     out_ready,
  output bmm_out_t out_data
);
  `include "bivariate_moment_merge_assert.svh"

  localparam logic [49:0] TermCap = 50'h2_0000_0000_0000;
  localparam logic signed [50:0] SMax = 51'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [50:0] SMin = -51'sh0_8000_0000_0000;

  bmm_in_t in_r;
  logic [31:0] agg_count_r;
  logic signed [31:0] agg_mean_x_r, agg_mean_y_r;
  logic [47:0] agg_m2_x_r, agg_m2_y_r;
  logic signed [47:0] agg_m_xy_r;
  logic sat_r;
  logic [32:0] n_r;
  logic [31:0] mdx_r, mdy_r;
  logic sdx_r, sdy_r;
  logic [55:0] x_r;
  logic [63:0] y_r;
  logic [127:0] acc_r, ma_r, dq_r;
  logic [63:0] mb_r;
  logic [33:0] rem_r;
  logic [49:0] tx_r, ty_r, txy_r;
  logic [31:0] qx_r, qy_r;
  logic out_valid_r;
  bmm_out_t out_data_r;

  logic signed [32:0] dx, dy;
  logic [32:0] n_cap;
  logic [63:0] op_a, op_b;
  logic [34:0] rem_sh, rem_sub;
  logic rem_ge;
  logic [49:0] q_cap;
  logic [50:0] m2x_sum, m2y_sum;
  logic signed [50:0] mxy_sum, mxy_term;
  logic signed [32:0] mx_new, my_new;
  bmm_out_t res;
  logic sat_nxt;

  assign dx = {in_data.part_mean_x[31], in_data.part_mean_x} - {agg_mean_x_r[31], agg_mean_x_r};
  assign dy = {in_data.part_mean_y[31], in_data.part_mean_y} - {agg_mean_y_r[31], agg_mean_y_r};
  assign n_cap = {1'b0, agg_count_r} + {9'b0, in_data.part_count};

  assign sts.bypass = in_r.first_part || (n_r == '0);
  assign sts.out_blocked = in_r.last_part && out_valid_r && !out_ready;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.job)
      JOB_X: begin
        op_a = {32'b0, agg_count_r};
        op_b = {40'b0, in_r.part_count};
      end
      JOB_SQX: begin
        op_a = {32'b0, mdx_r};
        op_b = {32'b0, mdx_r};
      end
      JOB_XY: begin
        op_a = {32'b0, mdx_r};
        op_b = {32'b0, mdy_r};
      end
      JOB_SQY: begin
        op_a = {32'b0, mdy_r};
        op_b = {32'b0, mdy_r};
      end
      JOB_MX: begin
        op_a = {40'b0, in_r.part_count};
        op_b = {32'b0, mdx_r};
      end
      JOB_MY: begin
        op_a = {40'b0, in_r.part_count};
        op_b = {32'b0, mdy_r};
      end
      default: begin
        op_a = {8'b0, x_r};
        op_b = y_r;
      end
    endcase
  end

  assign rem_sh  = {rem_r, dq_r[127]};
  assign rem_ge  = rem_sh >= {2'b0, n_r};
  assign rem_sub = rem_sh - {2'b0, n_r};
  assign q_cap   = ((|dq_r[127:50]) || (dq_r[49] && (|dq_r[48:0]))) ? TermCap : dq_r[49:0];

  always_comb begin
    m2x_sum  = {3'b0, agg_m2_x_r} + {3'b0, in_r.part_m2_x} + {1'b0, tx_r};
    m2y_sum  = {3'b0, agg_m2_y_r} + {3'b0, in_r.part_m2_y} + {1'b0, ty_r};
    mxy_term = (sdx_r != sdy_r) ? -$signed({1'b0, txy_r}) : $signed({1'b0, txy_r});
    mxy_sum  = $signed({{3{agg_m_xy_r[47]}}, agg_m_xy_r})
             + $signed({{3{in_r.part_m_xy[47]}}, in_r.part_m_xy}) + mxy_term;
    mx_new   = sdx_r ? ({agg_mean_x_r[31], agg_mean_x_r} - $signed({1'b0, qx_r}))
                     : ({agg_mean_x_r[31], agg_mean_x_r} + $signed({1'b0, qx_r}));
    my_new   = sdy_r ? ({agg_mean_y_r[31], agg_mean_y_r} - $signed({1'b0, qy_r}))
                     : ({agg_mean_y_r[31], agg_mean_y_r} + $signed({1'b0, qy_r}));
    res      = '0;
    sat_nxt  = sat_r;
    priority if (in_r.first_part) begin
      res.total_count = {8'b0, in_r.part_count};
      res.mean_x      = in_r.part_mean_x;
      res.mean_y      = in_r.part_mean_y;
      res.m2_x        = in_r.part_m2_x;
      res.m2_y        = in_r.part_m2_y;
      res.m_xy        = in_r.part_m_xy;
      sat_nxt         = 1'b0;
    end else if (n_r == '0) begin
      res.total_count = agg_count_r;
      res.mean_x      = agg_mean_x_r;
      res.mean_y      = agg_mean_y_r;
      res.m2_x        = agg_m2_x_r;
      res.m2_y        = agg_m2_y_r;
      res.m_xy        = agg_m_xy_r;
    end else begin
      res.total_count = n_r[32] ? '1 : n_r[31:0];
      res.mean_x      = mx_new[31:0];
      res.mean_y      = my_new[31:0];
      res.m2_x        = (m2x_sum[50:48] != '0) ? '1 : m2x_sum[47:0];
      res.m2_y        = (m2y_sum[50:48] != '0) ? '1 : m2y_sum[47:0];
      if (mxy_sum > SMax) begin
        res.m_xy = SMax[47:0];
      end else if (mxy_sum < SMin) begin
        res.m_xy = SMin[47:0];
      end else begin
        res.m_xy = mxy_sum[47:0];
      end
      sat_nxt = sat_r || n_r[32] || (m2x_sum[50:48] != '0) || (m2y_sum[50:48] != '0) ||
                (mxy_sum > SMax) || (mxy_sum < SMin);
    end
    res.saturated = sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_count_r  <= '0;
      agg_mean_x_r <= '0;
      agg_mean_y_r <= '0;
      agg_m2_x_r   <= '0;
      agg_m2_y_r   <= '0;
      agg_m_xy_r   <= '0;
      sat_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.commit) begin
        agg_count_r  <= res.total_count;
        agg_mean_x_r <= res.mean_x;
        agg_mean_y_r <= res.mean_y;
        agg_m2_x_r   <= res.m2_x;
        agg_m2_y_r   <= res.m2_y;
        agg_m_xy_r   <= res.m_xy;
        sat_r        <= sat_nxt;
        if (in_r.last_part) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && in_r.last_part) begin
      out_data_r <= res;
    end
    if (cmd.capture) begin
      in_r  <= in_data;
      n_r   <= n_cap;
      sdx_r <= dx[32];
      sdy_r <= dy[32];
      mdx_r <= dx[32] ? 32'(-dx) : dx[31:0];
      mdy_r <= dy[32] ? 32'(-dy) : dy[31:0];
    end
    if (cmd.init) begin
      if (job_is_div(cmd.job)) begin
        rem_r <= '0;
        if ((cmd.job == JOB_QX) || (cmd.job == JOB_QY)) begin
          dq_r <= acc_r;
        end else begin
          dq_r <= acc_r >> FRAC_BITS;
        end
      end else begin
        acc_r <= '0;
        ma_r  <= {64'b0, op_a};
        mb_r  <= op_b;
      end
    end
    if (cmd.step) begin
      if (job_is_div(cmd.job)) begin
        rem_r <= rem_ge ? rem_sub[33:0] : rem_sh[33:0];
        dq_r  <= {dq_r[126:0], rem_ge};
      end else begin
        if (mb_r[0]) begin
          acc_r <= acc_r + ma_r;
        end
        ma_r <= {ma_r[126:0], 1'b0};
        mb_r <= {1'b0, mb_r[63:1]};
      end
    end
    if (cmd.wb) begin
      unique case (cmd.job)
        JOB_X:   x_r   <= acc_r[55:0];
        JOB_SQX: y_r   <= acc_r[63:0];
        JOB_XY:  y_r   <= acc_r[63:0];
        JOB_SQY: y_r   <= acc_r[63:0];
        JOB_DX:  tx_r  <= q_cap;
        JOB_DXY: txy_r <= q_cap;
        JOB_DY:  ty_r  <= q_cap;
        JOB_QX:  qx_r  <= dq_r[31:0];
        JOB_QY:  qy_r  <= dq_r[31:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BMM_ASSERT_IMP(a_rem_below_divisor, cmd.step && job_is_div(cmd.job), rem_r < n_r)
  `BMM_ASSERT_IMP(a_mean_step_bounded, cmd.commit && !sts.bypass, (qx_r <= mdx_r) && (qy_r <= mdy_r))
  `BMM_ASSERT_NXT(a_count_sat_flags, cmd.commit && !sts.bypass && n_r[32], sat_r)

endmodule

// ===== bench/bivariate_moment_merge_checker.sv =====
// ---------------------------------------------------------------------------
// Bivariate moment merge checker
// Watches both channels, keeps its own copy of the running aggregate to
// predict each result transaction, and compares results field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bivariate_moment_merge_checker
  import bmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  bmm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  bmm_out_t out_data,
  output int       errors,
  output int       pending
);

  localparam int FRAC = 16;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000_0000;
  localparam longint unsigned TERM_LIMIT = 64'd1 << 49;

  longint unsigned sum_count;
  longint          sum_mean_x;
  longint          sum_mean_y;
  longint unsigned sum_m2_x;
  longint unsigned sum_m2_y;
  longint          sum_m_xy;
  logic            sum_sat;
  bmm_out_t        expected_results[$];

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint shifted_mean(longint m, longint d, longint unsigned nb,
                                          longint unsigned n);
    longint unsigned q;
    q = (nb * magnitude(d)) / n;
    return d < 0 ? m - longint'(q) : m + longint'(q);
  endfunction

  function automatic longint unsigned cross_term(longint unsigned nold,
                                                 longint unsigned nb,
                                                 longint unsigned ma,
                                                 longint unsigned mb,
                                                 longint unsigned n);
    logic [127:0] p;
    logic [127:0] q;
    p = 128'(nold * nb) * 128'(ma * mb);
    q = (p >> FRAC) / 128'(n);
    return (q > 128'(TERM_LIMIT)) ? TERM_LIMIT : longint'(q[63:0]);
  endfunction

  function automatic longint unsigned sat_add48(longint unsigned a, longint unsigned b,
                                                longint unsigned c);
    longint unsigned s;
    s = a + b + c;
    if (s > MASK48) begin
      sum_sat = 1'b1;
      return MASK48;
    end
    return s;
  endfunction

  task automatic merge_part(input bmm_in_t p);
    longint unsigned nb, nold, n, tx, ty, txy;
    longint          dx, dy, sxy;
    bmm_out_t        r;
    nb = p.part_count;
    if (p.first_part) begin
      sum_count  = nb;
      sum_mean_x = p.part_mean_x;
      sum_mean_y = p.part_mean_y;
      sum_m2_x   = p.part_m2_x;
      sum_m2_y   = p.part_m2_y;
      sum_m_xy   = p.part_m_xy;
      sum_sat    = 1'b0;
    end else begin
      nold = sum_count;
      n = nold + nb;
      if (n != 0) begin
        dx = longint'(p.part_mean_x) - sum_mean_x;
        dy = longint'(p.part_mean_y) - sum_mean_y;
        tx = cross_term(nold, nb, magnitude(dx), magnitude(dx), n);
        ty = cross_term(nold, nb, magnitude(dy), magnitude(dy), n);
        txy = cross_term(nold, nb, magnitude(dx), magnitude(dy), n);
        sxy = sum_m_xy + longint'(p.part_m_xy) +
              (((dx < 0) != (dy < 0)) ? -longint'(txy) : longint'(txy));
        sum_m2_x = sat_add48(sum_m2_x, p.part_m2_x, tx);
        sum_m2_y = sat_add48(sum_m2_y, p.part_m2_y, ty);
        if (sxy > SAT_HI) begin
          sxy = SAT_HI;
          sum_sat = 1'b1;
        end
        if (sxy < SAT_LO) begin
          sxy = SAT_LO;
          sum_sat = 1'b1;
        end
        sum_m_xy = sxy;
        sum_mean_x = shifted_mean(sum_mean_x, dx, nb, n);
        sum_mean_y = shifted_mean(sum_mean_y, dy, nb, n);
        if (n > 64'hFFFF_FFFF) begin
          n = 64'hFFFF_FFFF;
          sum_sat = 1'b1;
        end
        sum_count = n;
      end
    end
    if (p.last_part) begin
      r.total_count = sum_count[31:0];
      r.mean_x      = sum_mean_x[31:0];
      r.mean_y      = sum_mean_y[31:0];
      r.m2_x        = sum_m2_x[47:0];
      r.m2_y        = sum_m2_y[47:0];
      r.m_xy        = sum_m_xy[47:0];
      r.saturated   = sum_sat;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result(input bmm_out_t a);
    bmm_out_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result transaction %h", $time, a);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (a.total_count !== e.total_count) begin
      $display("%0t: total_count expected %0d actual %0d", $time, e.total_count,
               a.total_count);
      errors++;
    end
    if (a.mean_x !== e.mean_x) begin
      $display("%0t: mean_x expected %0d actual %0d", $time, e.mean_x, a.mean_x);
      errors++;
    end
    if (a.mean_y !== e.mean_y) begin
      $display("%0t: mean_y expected %0d actual %0d", $time, e.mean_y, a.mean_y);
      errors++;
    end
    if (a.m2_x !== e.m2_x) begin
      $display("%0t: m2_x expected %0d actual %0d", $time, e.m2_x, a.m2_x);
      errors++;
    end
    if (a.m2_y !== e.m2_y) begin
      $display("%0t: m2_y expected %0d actual %0d", $time, e.m2_y, a.m2_y);
      errors++;
    end
    if (a.m_xy !== e.m_xy) begin
      $display("%0t: m_xy expected %0d actual %0d", $time, e.m_xy, a.m_xy);
      errors++;
    end
    if (a.saturated !== e.saturated) begin
      $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
               a.saturated);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    sum_count = 0;
    sum_mean_x = 0;
    sum_mean_y = 0;
    sum_m2_x = 0;
    sum_m2_y = 0;
    sum_m_xy = 0;
    sum_sat = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) merge_part(in_data);
      if (out_valid && out_ready) check_result(out_data);
      pending = expected_results.size();
    end
  end

endmodule

// ===== bench/bivariate_moment_merge_tb.sv =====
// ---------------------------------------------------------------------------
// Bivariate moment merge testbench
// Drives directed and random partial summaries with varying idle and stall
// patterns; a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bivariate_moment_merge_tb;
  import bmm_pkg::*;

  localparam int DRAIN_CYCLES = 1500;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bmm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bmm_out_t out_data;
  int       errors;
  int       pending;
  int       sender_idle;
  int       receiver_stall;
  int       sent;

  bivariate_moment_merge uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  bivariate_moment_merge_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall);
    end
  end

  task automatic send_part(input bmm_in_t p);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic bmm_in_t random_part(input logic first, input logic last);
    bmm_in_t p;
    p.first_part = first;
    p.last_part = last;
    case ($urandom_range(9))
      0: p.part_count = 24'd0;
      1: p.part_count = 24'hFF_FFFF;
      2: p.part_count = 24'($urandom);
      default: p.part_count = 24'($urandom_range(1, 1000));
    endcase
    if ($urandom_range(3) == 0) begin
      p.part_mean_x = $urandom;
      p.part_mean_y = $urandom;
    end else begin
      p.part_mean_x = $signed($urandom_range(0, 20_000_000)) - 10_000_000;
      p.part_mean_y = $signed($urandom_range(0, 20_000_000)) - 10_000_000;
    end
    if ($urandom_range(3) == 0) begin
      p.part_m2_x = 48'({$urandom, $urandom});
      p.part_m2_y = 48'({$urandom, $urandom});
      p.part_m_xy = 48'({$urandom, $urandom});
    end else begin
      p.part_m2_x = 48'($urandom_range(0, 100_000_000));
      p.part_m2_y = 48'($urandom_range(0, 100_000_000));
      p.part_m_xy = 48'($signed($urandom_range(0, 100_000_000)) - 50_000_000);
    end
    return p;
  endfunction

  function automatic bmm_in_t make_part(input logic first, input logic last,
                                        input logic [23:0] cnt,
                                        input logic [31:0] mx, input logic [31:0] my,
                                        input logic [47:0] m2x, input logic [47:0] m2y,
                                        input logic [47:0] mxy);
    bmm_in_t p;
    p.first_part = first;
    p.last_part = last;
    p.part_count = cnt;
    p.part_mean_x = mx;
    p.part_mean_y = my;
    p.part_m2_x = m2x;
    p.part_m2_y = m2y;
    p.part_m_xy = mxy;
    return p;
  endfunction

  task automatic random_phase(input int items, input int idle, input int stall);
    int len;
    int k;
    sender_idle = idle;
    receiver_stall = stall;
    k = 0;
    while (k < items) begin
      if ($urandom_range(99) < 15) begin
        send_part(random_part(1'($urandom_range(1)), 1'($urandom_range(1))));
        k++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          send_part(random_part(i == 0, i == len - 1));
        end
        k += len;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    sender_idle = 0;
    receiver_stall = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_part(make_part(1'b1, 1'b1, 24'd5, 32'h0001_0000, 32'hFFFF_0000, 48'd100, 48'd200,
                        -48'sd50));
    send_part(make_part(1'b1, 1'b0, 24'd0, 32'd0, 32'd0, 48'd0, 48'd0, 48'd0));
    send_part(make_part(1'b0, 1'b1, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000, 48'd7, 48'd9,
                        48'd3));
    send_part(make_part(1'b1, 1'b0, 24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        48'hFFFF_FFFF_0000, 48'hFFFF_FFFF_0000, 48'h7FFF_FFFF_0000));
    send_part(make_part(1'b0, 1'b1, 24'hFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000));
    send_part(make_part(1'b1, 1'b0, 24'd1000, 32'h8000_0000, 32'h8000_0000, 48'd0, 48'd0,
                        48'h7FFF_FFFF_FFFF));
    send_part(make_part(1'b0, 1'b1, 24'd1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd0, 48'd0,
                        48'h7FFF_FFFF_FFFF));
    send_part(make_part(1'b1, 1'b0, 24'd3, 32'h0000_8000, 32'h0002_0000, 48'd1, 48'd1,
                        48'd0));
    send_part(make_part(1'b0, 1'b0, 24'd0, 32'h1234_5678, 32'h9ABC_DEF0, 48'd0, 48'd0,
                        48'd0));
    send_part(make_part(1'b0, 1'b0, 24'd2, 32'hFFFF_8000, 32'h0001_0000, 48'd4, 48'd4,
                        -48'sd4));
    send_part(make_part(1'b0, 1'b1, 24'd7, 32'd0, 32'd0, 48'd10, 48'd20, 48'd30));

    random_phase(300, 0, 0);

    // The stored count runs past its top, so the count saturates.
    send_part(make_part(1'b1, 1'b0, 24'hFF_FFFF, 32'h0001_0000, 32'h0001_0000, 48'd0,
                        48'd0, 48'd0));
    for (int i = 0; i < 257; i++) begin
      send_part(make_part(1'b0, i == 256, 24'hFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                          48'd1, 48'd1, 48'd0));
    end

    random_phase(250, 66, 0);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    random_phase(250, 0, 66);
    random_phase(250, 8, 8);

    in_valid <= 1'b0;
    sender_idle = 0;
    receiver_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bmm_pkg.sv
rtl/core/bmm_ctrl.sv
rtl/core/bmm_dp.sv
rtl/core/bivariate_moment_merge.sv
bench/bivariate_moment_merge_checker.sv
bench/bivariate_moment_merge_tb.sv
